// File: rtl/core/checked_stack_machine_assert.svh
// assertion macros for the checked stack machine
`ifndef CHECKED_STACK_MACHINE_ASSERT_SVH
`define CHECKED_STACK_MACHINE_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define CSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSM_ASSERT(label, clk, rst_n, prop, msg)
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/cstk_pkg.sv
// shared types and constants of the checked stack machine
package cstk_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W        = 64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_DUP  = 2'd1,
    OP_SWAP = 2'd2,
    OP_ADD  = 2'd3
  } cstk_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_SKIP  = 2'd3
  } cstk_status_e;

  // one instruction as held in the input register
  typedef struct packed {
    cstk_op_e                   kind;
    logic signed [WORD_W-1:0]   imm;
    logic                       eop;
  } cstk_item_t;

  // enables from the execute stage to the spill store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cstk_mem_ctl_t;

  // execute stage status, for the checks at the top level
  typedef struct packed {
    logic fire;
    logic err;
    logic fail;
    logic eop;
  } cstk_info_t;

endpackage

// File: rtl/core/cstk_inreg.sv
// input register: holds one instruction until the execute stage takes it
module cstk_inreg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic signed [63:0]      immediate_i,
  input  logic                    end_of_program_i,
  input  logic                    take_i,
  output logic                    item_vld_o,
  output cstk_pkg::cstk_item_t    item_o
);

  logic                 vld_q;
  logic                 vld_d;
  logic                 load;
  cstk_pkg::cstk_item_t item_q;

  // free when empty or when the held item leaves this cycle
  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.kind <= cstk_pkg::cstk_op_e'(kind_i);
      item_q.imm  <= immediate_i;
      item_q.eop  <= end_of_program_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

// File: rtl/core/cstk_store.sv
// spill store for the entries below the two cached top entries
module cstk_store #(
  parameter int unsigned DEPTH = cstk_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  cstk_pkg::cstk_mem_ctl_t           ctl_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic signed [cstk_pkg::WORD_W-1:0] wr_data_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic signed [cstk_pkg::WORD_W-1:0] rd_data_o
);

  logic signed [cstk_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [cstk_pkg::WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // prefetch of the third entry, bypassing a write to the same slot
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      if (ctl_i.wr_en && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/core/cstk_exec.sv
// execute stage: checks, top two entries, height, sticky error, result register
module cstk_exec #(
  parameter int unsigned DEPTH = cstk_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned HW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_vld_i,
  input  cstk_pkg::cstk_item_t               item_i,
  output logic                               take_o,
  output cstk_pkg::cstk_mem_ctl_t            mem_ctl_o,
  output logic [AW-1:0]                      wr_addr_o,
  output logic signed [cstk_pkg::WORD_W-1:0] wr_data_o,
  output logic [AW-1:0]                      rd_addr_o,
  input  logic signed [cstk_pkg::WORD_W-1:0] rd_data_i,
  output cstk_pkg::cstk_info_t               info_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cstk_pkg::WORD_W-1:0] top_value_o,
  output logic [HW-1:0]                      height_o,
  output logic [1:0]                         status_o,
  output logic                               program_done_o
);

  localparam logic [HW-1:0] HMAX = HW'(DEPTH);

  logic signed [cstk_pkg::WORD_W-1:0] top_q, top_d;
  logic signed [cstk_pkg::WORD_W-1:0] nxt_q, nxt_d;
  logic [HW-1:0]                      height_q, height_d;
  logic                               err_q, err_d;
  logic                               fire;
  logic                               under;
  logic                               over;
  logic                               grow;
  logic [HW-1:0]                      wr_pos;
  logic [HW-1:0]                      rd_pos;
  cstk_pkg::cstk_status_e             status;

  logic                               out_vld_q;
  logic signed [cstk_pkg::WORD_W-1:0] out_top_q;
  logic [HW-1:0]                      out_height_q;
  cstk_pkg::cstk_status_e             out_status_q;
  logic                               out_done_q;

  always_comb begin
    fire  = item_vld_i && (!out_vld_q || !out_stall_i);
    under = ((item_i.kind == cstk_pkg::OP_DUP) && (height_q == '0)) ||
            (((item_i.kind == cstk_pkg::OP_SWAP) || (item_i.kind == cstk_pkg::OP_ADD)) &&
             (height_q < HW'(2)));
    grow  = (item_i.kind == cstk_pkg::OP_PUSH) || (item_i.kind == cstk_pkg::OP_DUP);
    over  = grow && (height_q >= HMAX);

    if (err_q) begin
      status = cstk_pkg::ST_SKIP;
    end else if (under) begin
      status = cstk_pkg::ST_UNDER;
    end else if (over) begin
      status = cstk_pkg::ST_OVER;
    end else begin
      status = cstk_pkg::ST_OK;
    end

    top_d    = top_q;
    nxt_d    = nxt_q;
    height_d = height_q;
    if (status == cstk_pkg::ST_OK) begin
      case (item_i.kind)
        cstk_pkg::OP_PUSH: begin
          top_d    = item_i.imm;
          nxt_d    = top_q;
          height_d = height_q + HW'(1);
        end
        cstk_pkg::OP_DUP: begin
          nxt_d    = top_q;
          height_d = height_q + HW'(1);
        end
        cstk_pkg::OP_SWAP: begin
          top_d = nxt_q;
          nxt_d = top_q;
        end
        cstk_pkg::OP_ADD: begin
          top_d    = top_q + nxt_q;
          nxt_d    = rd_data_i;
          height_d = height_q - HW'(1);
        end
        default: begin
          top_d = top_q;
        end
      endcase
    end

    // old second entry spills to the store when the stack grows
    wr_pos = height_q - HW'(2);
    rd_pos = height_d - HW'(3);

    mem_ctl_o.wr_en = fire && (status == cstk_pkg::ST_OK) && grow &&
                      (height_q >= HW'(2));
    mem_ctl_o.rd_en = fire;

    err_d = item_i.eop ? 1'b0 : (err_q || (status != cstk_pkg::ST_OK));
  end

  assign take_o    = fire;
  assign wr_addr_o = wr_pos[AW-1:0];
  assign wr_data_o = nxt_q;
  assign rd_addr_o = rd_pos[AW-1:0];

  assign info_o.fire = fire;
  assign info_o.err  = err_q;
  assign info_o.fail = (status == cstk_pkg::ST_UNDER) || (status == cstk_pkg::ST_OVER);
  assign info_o.eop  = item_i.eop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= '0;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        height_q  <= height_d;
        err_q     <= err_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      top_q        <= top_d;
      nxt_q        <= nxt_d;
      out_top_q    <= (height_d == '0) ? '0 : top_d;
      out_height_q <= height_d;
      out_status_q <= status;
      out_done_q   <= item_i.eop;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign top_value_o    = out_top_q;
  assign height_o       = out_height_q;
  assign status_o       = out_status_q;
  assign program_done_o = out_done_q;

endmodule

// File: rtl/core/checked_stack_machine.sv
// top level of the checked stack machine
// Executes one stack instruction (push, dup, swap, add) per item and returns one
// result per item: the top entry, the height and a status. One item per clock
// cycle is sustained while results are taken; a held result stalls the execute
// stage, which keeps its item in the input register and stalls the input. The
// execute stage works from the input register straight into the result
// register, which is loaded whenever an item is executed. The top
// two entries live in registers and deeper entries in a one-write, one-read
// store whose third entry is prefetched after every executed item, so the
// execute stage never waits on the store. Underflow and overflow set a sticky
// error; later items are reported as skipped until an item marked end of
// program is processed.
`include "checked_stack_machine_assert.svh"
module checked_stack_machine #(
  parameter int unsigned DEPTH = cstk_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [63:0]          immediate_i,
  input  logic                        end_of_program_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [63:0]          top_value_o,
  output logic [$clog2(DEPTH+1)-1:0]  height_o,
  output logic [1:0]                  status_o,
  output logic                        program_done_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned HW = $clog2(DEPTH + 1);

  logic                               item_vld;
  cstk_pkg::cstk_item_t               item;
  logic                               take;
  cstk_pkg::cstk_mem_ctl_t            mem_ctl;
  logic [AW-1:0]                      wr_addr;
  logic signed [cstk_pkg::WORD_W-1:0] wr_data;
  logic [AW-1:0]                      rd_addr;
  logic signed [cstk_pkg::WORD_W-1:0] rd_data;
  cstk_pkg::cstk_info_t               info;

  cstk_inreg u_inreg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .immediate_i      (immediate_i),
    .end_of_program_i (end_of_program_i),
    .take_i           (take),
    .item_vld_o       (item_vld),
    .item_o           (item)
  );

  cstk_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cstk_exec #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .HW    (HW)
  ) u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_vld_i     (item_vld),
    .item_i         (item),
    .take_o         (take),
    .mem_ctl_o      (mem_ctl),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .info_o         (info),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .top_value_o    (top_value_o),
    .height_o       (height_o),
    .status_o       (status_o),
    .program_done_o (program_done_o)
  );

  `CSM_ASSERT(a_height_in_range, clk_i, rst_ni, !out_valid_o || (height_o <= HW'(DEPTH)), "height beyond depth")
  `CSM_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, info.fire, out_valid_o, "executed item left no result")
  `CSM_ASSERT_NEXT(a_fail_is_sticky, clk_i, rst_ni, info.fire && info.fail && !info.eop, info.err, "failed check did not set the error")
  `CSM_ASSERT_NEXT(a_pending_err_skips, clk_i, rst_ni, info.fire && info.err, status_o == cstk_pkg::ST_SKIP, "item not skipped under pending error")

endmodule
